/* rtl/core/tap_pkg.sv */
// Shared types, constants and datapath step functions for the two-anchor position solver.
package tap_pkg;

  // Distance limit
  localparam int DIST_BITS = 15;
  localparam logic [31:0] DIST_MAX = 32'((64'd1 << DIST_BITS) - 64'd1);
  localparam logic [14:0] POS_MAX = 15'h7FFF;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASELINE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOF_FLOOR = 2'd1;
  localparam int CFG_DATA_BITS = 15;

  // Register reset values
  localparam logic [11:0] BASELINE_RST  = 12'd120;
  localparam logic [14:0] TOF_FLOOR_RST = 15'd500;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIST = 2'd1;
  localparam logic [1:0] ST_NO_TRI   = 2'd2;

  // Pipeline depths (two result bits per stage)
  localparam int ROOT_STAGES  = 16;
  localparam int DIV_STAGES   = 16;
  localparam int ROOT2_STAGES = 8;

  // Per-item fields that travel along the pipeline
  typedef struct packed {
    logic [14:0] a;
    logic [14:0] b;
    logic [11:0] c;
    logic        sat;
    logic [1:0]  status;
  } side_t;

  // Square root partial state
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } root_t;

  // Divider partial state
  typedef struct packed {
    logic [11:0] rem;
    logic        q;
  } div_t;

  // One digit of the bitwise integer square root
  function automatic root_t root_step(root_t cur, logic [1:0] pair);
    logic [35:0] r;
    logic [35:0] t;
    logic [35:0] d;
    root_t       res;
    r = {cur.rem, pair};
    t = {2'b00, cur.root, 2'b01};
    d = r - t;
    if (r >= t) begin
      res.rem  = d[33:0];
      res.root = {cur.root[30:0], 1'b1};
    end else begin
      res.rem  = r[33:0];
      res.root = {cur.root[30:0], 1'b0};
    end
    return res;
  endfunction

  // One bit of restoring division by the baseline
  function automatic div_t div_step(logic [11:0] rem, logic nbit, logic [11:0] c);
    logic [12:0] r;
    logic [12:0] d;
    div_t        res;
    r = {rem, nbit};
    d = r - {1'b0, c};
    if (r >= {1'b0, c}) begin
      res.rem = d[11:0];
      res.q   = 1'b1;
    end else begin
      res.rem = r[11:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

/* rtl/core/tap_if.sv */
// Channel interfaces: measurement input, position output and configuration writes.
interface tap_meas_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tof_a;
  logic [31:0]        rssi_a;
  logic signed [31:0] tof_b;
  logic [31:0]        rssi_b;
  modport source (output valid, tof_a, rssi_a, tof_b, rssi_b, input ready);
  modport sink   (input valid, tof_a, rssi_a, tof_b, rssi_b, output ready);
endinterface

interface tap_fix_if;
  logic        valid;
  logic        ready;
  logic [14:0] dist_a;
  logic [14:0] dist_b;
  logic [14:0] pos_x;
  logic [14:0] pos_y;
  logic [1:0]  status;
  logic        saturated;
  modport source (output valid, dist_a, dist_b, pos_x, pos_y, status, saturated,
                  input ready);
  modport sink   (input valid, dist_a, dist_b, pos_x, pos_y, status, saturated,
                  output ready);
endinterface

interface tap_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/tap_pick.sv */
// Distance selection for one beacon: floor test, then saturation to the limit.
module tap_pick
  import tap_pkg::*;
(
  input  logic signed [31:0] tof,
  input  logic [31:0]        rssi,
  input  logic [14:0]        tof_floor,
  output logic [14:0]        dist_sel,
  output logic               sat
);

  logic        use_rssi;
  logic [31:0] raw;

  // Signed compare of time of flight against the floor
  assign use_rssi = tof < $signed({17'b0, tof_floor});
  assign raw      = use_rssi ? rssi : tof;

  // Clamp to the distance limit
  assign sat      = raw > DIST_MAX;
  assign dist_sel = sat ? DIST_MAX[14:0] : raw[14:0];

endmodule

/* rtl/core/two_anchor_position_solver.sv */
// Top level: pipelined Heron-formula position solver for two beacons.
// An input item passes through 47 register stages, the output register on fix
// being the last. Throughput: one item per cycle; the pipeline advances
// whenever the output register is empty or being taken, so a stall on fix holds
// every stage. Depth is set by the 64-bit square root, the 32-bit divider and
// the 30-bit square root, each resolving two bits per stage. Reset (rst,
// synchronous) empties the pipeline and loads baseline 120 cm and floor 500 cm.
module two_anchor_position_solver
  import tap_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tap_meas_if.sink  meas,
  tap_fix_if.source fix,
  tap_cfg_if.sink   cfg
);

  logic        en;
  logic [11:0] baseline;
  logic [14:0] tof_floor;

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline  <= BASELINE_RST;
      tof_floor <= TOF_FLOOR_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_BASELINE)  baseline  <= cfg.data[11:0];
      if (cfg.index == REG_TOF_FLOOR) tof_floor <= cfg.data;
    end
  end

  // Global advance: output register empty or being taken
  assign en         = !fix.valid || fix.ready;
  assign meas.ready = en;

  // Stage 0: distance selection
  logic [14:0] pa, pb;
  logic        sa, sb;
  side_t       side0;
  logic        v0;

  tap_pick u_pick_a (.tof(meas.tof_a), .rssi(meas.rssi_a), .tof_floor(tof_floor),
                     .dist_sel(pa), .sat(sa));
  tap_pick u_pick_b (.tof(meas.tof_b), .rssi(meas.rssi_b), .tof_floor(tof_floor),
                     .dist_sel(pb), .sat(sb));

  always_ff @(posedge clk) begin
    if (en) begin
      side0.a      <= pa;
      side0.b      <= pb;
      side0.c      <= baseline;
      side0.sat    <= sa | sb;
      side0.status <= (pa == '0 || pb == '0 || baseline == '0) ? ST_BAD_DIST : ST_OK;
    end
  end

  // Stage 1: half perimeter and its differences
  logic [16:0]        sum0;
  logic [15:0]        s1;
  logic signed [16:0] fa1, fb1, fc1;
  side_t              side1;
  logic               v1;

  assign sum0 = {2'b0, side0.a} + {2'b0, side0.b} + {5'b0, side0.c};
  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= sum0[16:1];
      fa1   <= $signed({1'b0, sum0[16:1]}) - $signed({2'b0, side0.a});
      fb1   <= $signed({1'b0, sum0[16:1]}) - $signed({2'b0, side0.b});
      fc1   <= $signed({1'b0, sum0[16:1]}) - $signed({5'b0, side0.c});
      side1 <= side0;
    end
  end

  // Stage 2: two partial products, each below 2^31 in magnitude
  logic signed [33:0] prod_a, prod_b;
  logic signed [31:0] p1, p2;
  side_t              side2;
  logic               v2;

  assign prod_a = $signed({1'b0, s1}) * fa1;
  assign prod_b = fb1 * fc1;
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= prod_a[31:0];
      p2    <= prod_b[31:0];
      side2 <= side1;
    end
  end

  // Stage 3: n = s(s-a)(s-b)(s-c); negative n means no triangle
  logic signed [63:0] n3;
  side_t              side3;
  logic               v3;
  logic signed [63:0] nprod;

  assign nprod = p1 * p2;
  always_ff @(posedge clk) begin
    if (en) begin
      n3    <= nprod;
      side3 <= side2;
      if (side2.status == ST_OK && nprod[63]) side3.status <= ST_NO_TRI;
    end
  end

  // isqrt(4n): two digits per stage
  root_t       rt  [ROOT_STAGES];
  logic [63:0] rv  [ROOT_STAGES];
  side_t       rsd [ROOT_STAGES];
  logic        rvld[ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
    root_t       cur_in, mid, nxt;
    logic [63:0] v_in;
    side_t       s_in;
    logic        vld_in;
    if (k == 0) begin : g_first
      assign cur_in = '0;
      assign v_in   = {n3[61:0], 2'b00};
      assign s_in   = side3;
      assign vld_in = v3;
    end else begin : g_next
      assign cur_in = rt[k-1];
      assign v_in   = rv[k-1];
      assign s_in   = rsd[k-1];
      assign vld_in = rvld[k-1];
    end
    assign mid = root_step(cur_in, v_in[63-4*k -: 2]);
    assign nxt = root_step(mid, v_in[61-4*k -: 2]);
    always_ff @(posedge clk) begin
      if (rst) rvld[k] <= 1'b0;
      else if (en) rvld[k] <= vld_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt[k]  <= nxt;
        rv[k]  <= v_in;
        rsd[k] <= s_in;
      end
    end
  end

  // y = root / c: restoring divider, two quotient bits per stage
  logic [11:0] drem[DIV_STAGES];
  logic [31:0] dq  [DIV_STAGES];
  logic [31:0] dnum[DIV_STAGES];
  side_t       dsd [DIV_STAGES];
  logic        dvld[DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [11:0] rem_in;
    logic [31:0] q_in, num_in;
    side_t       s_in;
    logic        vld_in;
    div_t        d1, d2;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign num_in = rt[ROOT_STAGES-1].root;
      assign s_in   = rsd[ROOT_STAGES-1];
      assign vld_in = rvld[ROOT_STAGES-1];
    end else begin : g_next
      assign rem_in = drem[k-1];
      assign q_in   = dq[k-1];
      assign num_in = dnum[k-1];
      assign s_in   = dsd[k-1];
      assign vld_in = dvld[k-1];
    end
    assign d1 = div_step(rem_in, num_in[31-2*k], s_in.c);
    assign d2 = div_step(d1.rem, num_in[30-2*k], s_in.c);
    always_ff @(posedge clk) begin
      if (rst) dvld[k] <= 1'b0;
      else if (en) dvld[k] <= vld_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem[k] <= d2.rem;
        dq[k]   <= {q_in[29:0], d1.q, d2.q};
        dnum[k] <= num_in;
        dsd[k]  <= s_in;
      end
    end
  end

  // Squares of a and y; y saturates for output
  logic [31:0] yq;
  logic [29:0] aa_m, yy_m;
  logic        ysmall_m;
  logic [14:0] py_m;
  side_t       side_m;
  logic        vm;
  logic [14:0] side_of_div_a;

  assign side_of_div_a = dsd[DIV_STAGES-1].a;
  assign yq = dq[DIV_STAGES-1];
  always_ff @(posedge clk) begin
    if (en) begin
      aa_m     <= side_of_div_a * side_of_div_a;
      yy_m     <= yq[14:0] * yq[14:0];
      ysmall_m <= (yq[31:15] == '0);
      py_m     <= (yq[31:15] == '0) ? yq[14:0] : POS_MAX;
      side_m   <= dsd[DIV_STAGES-1];
    end
  end

  // a^2 - y^2, clamped at zero
  logic [29:0] d_d;
  logic [14:0] py_d;
  side_t       side_d;
  logic        vd;

  always_ff @(posedge clk) begin
    if (en) begin
      d_d    <= (ysmall_m && aa_m > yy_m) ? aa_m - yy_m : '0;
      py_d   <= py_m;
      side_d <= side_m;
    end
  end

  // isqrt(a^2 - y^2): two digits per stage
  root_t       qt  [ROOT2_STAGES];
  logic [31:0] qv  [ROOT2_STAGES];
  logic [14:0] qpy [ROOT2_STAGES];
  side_t       qsd [ROOT2_STAGES];
  logic        qvld[ROOT2_STAGES];

  for (genvar k = 0; k < ROOT2_STAGES; k++) begin : g_root2
    root_t       cur_in, mid, nxt;
    logic [31:0] v_in;
    logic [14:0] py_in;
    side_t       s_in;
    logic        vld_in;
    if (k == 0) begin : g_first
      assign cur_in = '0;
      assign v_in   = {2'b00, d_d};
      assign py_in  = py_d;
      assign s_in   = side_d;
      assign vld_in = vd;
    end else begin : g_next
      assign cur_in = qt[k-1];
      assign v_in   = qv[k-1];
      assign py_in  = qpy[k-1];
      assign s_in   = qsd[k-1];
      assign vld_in = qvld[k-1];
    end
    assign mid = root_step(cur_in, v_in[31-4*k -: 2]);
    assign nxt = root_step(mid, v_in[29-4*k -: 2]);
    always_ff @(posedge clk) begin
      if (rst) qvld[k] <= 1'b0;
      else if (en) qvld[k] <= vld_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qt[k]  <= nxt;
        qv[k]  <= v_in;
        qpy[k] <= py_in;
        qsd[k] <= s_in;
      end
    end
  end

  // Output register; position zeroed on any error
  side_t ofs;
  assign ofs = qsd[ROOT2_STAGES-1];
  always_ff @(posedge clk) begin
    if (en) begin
      fix.dist_a    <= ofs.a;
      fix.dist_b    <= ofs.b;
      fix.status    <= ofs.status;
      fix.saturated <= ofs.sat;
      fix.pos_x     <= (ofs.status == ST_OK) ? qt[ROOT2_STAGES-1].root[14:0] : '0;
      fix.pos_y     <= (ofs.status == ST_OK) ? qpy[ROOT2_STAGES-1] : '0;
    end
  end

  // Valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      vm        <= 1'b0;
      vd        <= 1'b0;
      fix.valid <= 1'b0;
    end else if (en) begin
      v0        <= meas.valid;
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      vm        <= dvld[DIV_STAGES-1];
      vd        <= vm;
      fix.valid <= qvld[ROOT2_STAGES-1];
    end
  end

endmodule

/* test/tb_two_anchor_position_solver.sv */
// Testbench for the two-anchor position solver: random stimulus, predicted fixes, checks.
`timescale 1ns / 1ps
module tb_two_anchor_position_solver;
  import tap_pkg::*;

  typedef struct {
    logic signed [31:0] tof_a;
    logic [31:0]        rssi_a;
    logic signed [31:0] tof_b;
    logic [31:0]        rssi_b;
  } meas_t;

  typedef struct {
    logic [14:0] dist_a;
    logic [14:0] dist_b;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [1:0]  status;
    logic        saturated;
  } fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tap_meas_if meas ();
  tap_fix_if  fix ();
  tap_cfg_if  cfg ();

  two_anchor_position_solver dut (
    .clk  (clk),
    .rst  (rst),
    .meas (meas.sink),
    .fix  (fix.source),
    .cfg  (cfg.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers
  logic [11:0] baseline = BASELINE_RST;
  logic [14:0] tof_floor = TOF_FLOOR_RST;

  meas_t pending_meas[$];
  fix_t  expected_fixes[$];
  int    errors = 0;
  int    quiet_cycles = 0;
  bit    cfg_busy = 1'b0;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Pick TOF or RSSI distance and clamp to the limit
  function automatic logic [63:0] select_dist(logic signed [31:0] tof, logic [31:0] rssi,
                                              inout logic sat);
    logic [63:0] d;
    if (64'(signed'(tof)) < $signed({49'd0, tof_floor})) d = {32'd0, rssi};
    else d = {32'd0, tof};
    if (d > 64'd32767) begin
      d = 64'd32767;
      sat = 1'b1;
    end
    return d;
  endfunction

  function automatic fix_t solve_position(meas_t m);
    fix_t f;
    logic sat;
    logic [63:0] a, b, c, y, aa, yy;
    logic signed [63:0] s, n;
    sat = 1'b0;
    a = select_dist(m.tof_a, m.rssi_a, sat);
    b = select_dist(m.tof_b, m.rssi_b, sat);
    c = {52'd0, baseline};
    f.status = ST_OK;
    f.pos_x = '0;
    f.pos_y = '0;
    if (a == 0 || b == 0 || c == 0) begin
      f.status = ST_BAD_DIST;
    end else begin
      s = $signed(a + b + c) / 2;
      n = s * (s - $signed(a)) * (s - $signed(b)) * (s - $signed(c));
      if (n < 0) begin
        f.status = ST_NO_TRI;
      end else begin
        y = int_sqrt(n * 4) / c;
        aa = a * a;
        yy = y * y;
        f.pos_x = (aa > yy) ? 15'(int_sqrt(aa - yy)) : '0;
        f.pos_y = (y > 64'd32767) ? POS_MAX : 15'(y);
      end
    end
    f.dist_a = 15'(a);
    f.dist_b = 15'(b);
    f.saturated = sat;
    return f;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 8);
      2: return $urandom_range(0, 40000);
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  function automatic meas_t rand_meas();
    meas_t m;
    m.tof_a = rand_dist();
    m.rssi_a = rand_dist();
    m.tof_b = rand_dist();
    m.rssi_b = rand_dist();
    if ($urandom_range(0, 5) == 0) m.tof_a = -$signed({1'b0, 31'($urandom)});
    if ($urandom_range(0, 5) == 0) m.tof_b = -$signed({1'b0, 31'($urandom)});
    return m;
  endfunction

  function automatic meas_t make_meas(logic [31:0] ta, logic [31:0] ra,
                                      logic [31:0] tb, logic [31:0] rb);
    meas_t m;
    m.tof_a = ta;
    m.rssi_a = ra;
    m.tof_b = tb;
    m.rssi_b = rb;
    return m;
  endfunction

  // Input driver; the item on the bus stays at the queue head until its transfer
  int meas_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      meas.valid <= 1'b0;
    end else if (meas.valid && !meas.ready) begin
      // hold
    end else begin
      if (meas.valid) begin
        expected_fixes.push_back(solve_position(pending_meas.pop_front()));
      end
      if (meas_gap > 0) begin
        meas_gap <= meas_gap - 1;
        meas.valid <= 1'b0;
      end else if (pending_meas.size() > 0) begin
        meas_t m;
        m = pending_meas[0];
        meas.valid <= 1'b1;
        meas.tof_a <= m.tof_a;
        meas.rssi_a <= m.rssi_a;
        meas.tof_b <= m.tof_b;
        meas.rssi_b <= m.rssi_b;
        meas_gap <= gap_len();
      end else begin
        meas.valid <= 1'b0;
      end
    end
  end

  // Configuration write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      cfg.valid <= 1'b0;
      if (cfg.index == REG_BASELINE) baseline <= cfg.data[11:0];
      else if (cfg.index == REG_TOF_FLOOR) tof_floor <= cfg.data;
      cfg_busy <= 1'b0;
    end else if (cfg_busy && !cfg.valid) begin
      cfg.valid <= 1'b1;
      cfg.index <= cfg_index;
      cfg.data <= cfg_data;
    end
  end

  // Result monitor with random backpressure
  int fix_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      fix.ready <= 1'b0;
    end else begin
      if (fix.valid && fix.ready) begin
        if (expected_fixes.size() == 0) begin
          $error("fix transfer with no expected result");
          errors++;
        end else begin
          fix_t e;
          e = expected_fixes.pop_front();
          if (fix.dist_a !== e.dist_a) begin
            $error("dist_a exp %0d got %0d", e.dist_a, fix.dist_a); errors++;
          end
          if (fix.dist_b !== e.dist_b) begin
            $error("dist_b exp %0d got %0d", e.dist_b, fix.dist_b); errors++;
          end
          if (fix.pos_x !== e.pos_x) begin
            $error("pos_x exp %0d got %0d", e.pos_x, fix.pos_x); errors++;
          end
          if (fix.pos_y !== e.pos_y) begin
            $error("pos_y exp %0d got %0d", e.pos_y, fix.pos_y); errors++;
          end
          if (fix.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, fix.status); errors++;
          end
          if (fix.saturated !== e.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, fix.saturated); errors++;
          end
        end
      end
      if (fix_gap > 0) begin
        fix_gap <= fix_gap - 1;
        fix.ready <= 1'b0;
      end else begin
        fix.ready <= 1'b1;
        fix_gap <= gap_len();
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((meas.valid && meas.ready) || (fix.valid && fix.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_busy = 1'b1;
    while (cfg_busy) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_meas.size() != 0 || meas.valid || expected_fixes.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic directed_items();
    pending_meas.push_back(make_meas(100, 0, 100, 0));
    pending_meas.push_back(make_meas(600, 0, 600, 0));
    pending_meas.push_back(make_meas(0, 0, 700, 0));
    pending_meas.push_back(make_meas(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_meas.push_back(make_meas(32'hFFFF_FFFF, 32767, 32'd32768, 5));
    pending_meas.push_back(make_meas(10, 1000, 20, 1000));
    pending_meas.push_back(make_meas(0, 1, 0, 1));
    pending_meas.push_back(make_meas(0, 5000, 0, 100));
    pending_meas.push_back(make_meas(0, 60, 0, 60));
    pending_meas.push_back(make_meas(0, 32767, 0, 32767));
    pending_meas.push_back(make_meas(0, 32'hAAAA_AAAA, 0, 32'h5555_5555));
  endtask

  initial begin
    int phase;
    meas.valid = 1'b0;
    meas.tof_a = '0; meas.rssi_a = '0; meas.tof_b = '0; meas.rssi_b = '0;
    fix.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first
    directed_items();
    drain();
    // Sweep register settings, extremes included
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_BASELINE, 15'd1); write_reg(REG_TOF_FLOOR, 15'd0); end
        1: begin write_reg(REG_BASELINE, 15'd4095); write_reg(REG_TOF_FLOOR, 15'h7FFF); end
        2: begin write_reg(REG_BASELINE, 15'h7000); write_reg(REG_TOF_FLOOR, 15'd1000); end
        3: write_reg(2'd3, 15'd55);
        4: begin
          write_reg(REG_BASELINE, 15'($urandom_range(1, 4095)));
          write_reg(REG_TOF_FLOOR, 15'($urandom_range(0, 32767)));
        end
        default: begin write_reg(REG_BASELINE, 15'd120); write_reg(REG_TOF_FLOOR, 15'd500); end
      endcase
      if (phase < 2) directed_items();
      repeat (135) pending_meas.push_back(rand_meas());
      drain();
    end

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tap_pkg.sv
rtl/core/tap_if.sv
rtl/core/tap_pick.sv
rtl/core/two_anchor_position_solver.sv
test/tb_two_anchor_position_solver.sv
